// ----- rtl/srtn_pkg.sv -----
// Shared types and constants for the SRTN scheduler block.
// No dependencies; used by the channel interfaces and every RTL module.
package srtn_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 20;
  localparam int ID_W      = 4;
  localparam int ALU_W     = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Load status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One slot of the job table
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [TIME_W-1:0]  start;
  } slot_rec_t;

  // Shared subtractor operands and result
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

  // One result held in the output register
  typedef struct packed {
    logic              status;
    logic [ID_W-1:0]   slot_id;
    logic              idle;
    logic              new_segment;
    logic [TIME_W-1:0] segment_start;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [TIME_W-1:0] response_time;
    logic              all_done;
  } result_t;

endpackage

// ----- rtl/srtn_in_if.sv -----
// Request channel of the SRTN scheduler: valid/ready plus job fields.
// Depends on srtn_pkg for field widths.
interface srtn_in_if;
  import srtn_pkg::*;

  logic               valid;
  logic               ready;
  logic               command;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;

  modport source(output valid, command, arrival_time, burst_time, input ready);
  modport sink(input valid, command, arrival_time, burst_time, output ready);
endinterface

// ----- rtl/srtn_out_if.sv -----
// Result channel of the SRTN scheduler: valid/ready plus result fields.
// Depends on srtn_pkg for field widths.
interface srtn_out_if;
  import srtn_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [ID_W-1:0]   slot_id;
  logic              idle;
  logic              new_segment;
  logic [TIME_W-1:0] segment_start;
  logic              finished;
  logic [TIME_W-1:0] completion_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [TIME_W-1:0] waiting_time;
  logic [TIME_W-1:0] response_time;
  logic              all_done;

  modport source(output valid, status, slot_id, idle, new_segment, segment_start,
                 finished, completion_time, turnaround_time, waiting_time,
                 response_time, all_done, input ready);
  modport sink(input valid, status, slot_id, idle, new_segment, segment_start,
               finished, completion_time, turnaround_time, waiting_time,
               response_time, all_done, output ready);
endinterface

// ----- rtl/srtn_slot_mem.sv -----
// Job table memory: one write port, one read port with registered data.
// Depends on srtn_pkg (slot_rec_t).
module srtn_slot_mem #(
  parameter int SLOTS = srtn_pkg::SLOTS_DEF,
  localparam int IW = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  srtn_pkg::slot_rec_t wr_data,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output srtn_pkg::slot_rec_t rd_data
);
  import srtn_pkg::*;

  slot_rec_t mem_r [SLOTS];
  slot_rec_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, data in the next cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/srtn_alu.sv -----
// Shared subtractor: key compare during the scan, time differences after.
// Depends on srtn_pkg (alu_req_t, alu_res_t).
module srtn_alu (
  input  srtn_pkg::alu_req_t req,
  output srtn_pkg::alu_res_t res
);
  import srtn_pkg::*;

  logic [ALU_W:0] wide;

  // borrow out means a < b
  assign wide       = {1'b0, req.a} - {1'b0, req.b};
  assign res.diff   = wide[ALU_W-1:0];
  assign res.borrow = wide[ALU_W];

endmodule

// ----- rtl/srtn_preemptive_scheduler.sv -----
// Top level of the SRTN scheduler: sequencer, slot state and result register.
// Depends on srtn_pkg, srtn_in_if, srtn_out_if, srtn_slot_mem, srtn_alu.
//
//  Channel    Dir  Handshake      Carries
//  in_chan    in   valid/ready    command, arrival_time, burst_time
//  out_chan   out  valid/ready    status, slot_id, ... all_done (one per request)
//
// A load passes LOAD and RES. A tick scans the table one slot per cycle
// through its single read port and the shared subtractor, then PICK, and
// TAT, WT, RT only when the running job completes, before RES.
// rst_n is synchronous; it clears the table's done bits, counters and time.
// in_chan.ready is high only while the sequencer is idle; a result waiting
// in the output register does not hold off the next request until the
// following result is ready to load.
module srtn_preemptive_scheduler #(
  parameter int SLOTS = srtn_pkg::SLOTS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  srtn_in_if.sink     in_chan,
  srtn_out_if.source  out_chan
);
  import srtn_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LOAD = 8'b0000_0010,
    ST_SCAN = 8'b0000_0100,
    ST_PICK = 8'b0000_1000,
    ST_TAT  = 8'b0001_0000,
    ST_WT   = 8'b0010_0000,
    ST_RT   = 8'b0100_0000,
    ST_RES  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // control state
  logic [CW-1:0]     loaded_cnt_r;
  logic [CW-1:0]     fin_cnt_r;
  logic [TIME_W-1:0] cur_time_r;
  logic [SLOTS-1:0]  done_r;
  logic              last_valid_r;
  logic [IW-1:0]     last_slot_r;
  logic [CW-1:0]     scan_cnt_r;
  logic              pend_r;
  logic              found_r;
  logic              out_valid_r;

  // payload
  logic               cmd_r;
  logic [ARR_W-1:0]   arr_in_r;
  logic [BURST_W-1:0] burst_in_r;
  logic [TIME_W-1:0]  tick_time_r;
  logic [IW-1:0]      pend_idx_r;
  logic [IW-1:0]      best_idx_r;
  slot_rec_t          best_rec_r;
  logic [TIME_W-1:0]  ct_r;
  logic [TIME_W-1:0]  tat_r;
  logic [TIME_W-1:0]  wt_r;
  logic [TIME_W-1:0]  rt_r;
  logic               res_status_r;
  logic [IW-1:0]      res_slot_r;
  logic               res_idle_r;
  logic               res_newseg_r;
  logic               res_fin_r;
  result_t            out_r;

  logic               in_acc;
  logic [BURST_W-1:0] burst_fix;
  logic               table_full;
  logic               scan_rd;
  logic               scan_end;
  logic               cand_elig;
  logic               cand_take;
  logic [TIME_W-1:0]  time_inc;
  logic               first_run;
  logic [TIME_W-1:0]  start_eff;
  logic [BURST_W-1:0] rem_dec;
  logic               job_fin;
  logic               out_free;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  slot_rec_t          mem_wdata;
  slot_rec_t          mem_rdata;
  alu_req_t           alu_req;
  alu_res_t           alu_res;
  result_t            res_nxt;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign burst_fix     = (in_chan.burst_time == '0) ? BURST_W'(1) : in_chan.burst_time;
  assign table_full    = (loaded_cnt_r == SLOTS_CNT);
  assign time_inc      = (cur_time_r == TIME_MAX) ? TIME_MAX : cur_time_r + TIME_W'(1);
  assign out_free      = !out_valid_r || out_chan.ready;

  // scan: issue one read per cycle, judge the slot read last cycle
  assign scan_rd   = (state_r == ST_SCAN) && (scan_cnt_r < loaded_cnt_r);
  assign scan_end  = (state_r == ST_SCAN) && !scan_rd && !pend_r;
  assign cand_elig = pend_r && !done_r[pend_idx_r] &&
                     ({{(TIME_W-ARR_W){1'b0}}, mem_rdata.arrival} <= cur_time_r);
  assign cand_take = cand_elig && (!found_r || alu_res.borrow);

  // run step for the chosen job
  assign first_run = (best_rec_r.remaining == best_rec_r.burst);
  assign start_eff = first_run ? cur_time_r : best_rec_r.start;
  assign rem_dec   = best_rec_r.remaining - BURST_W'(1);
  assign job_fin   = (rem_dec == '0);

  // table write port: loads and run updates
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = best_idx_r;
    mem_wdata = '{arrival: best_rec_r.arrival, burst: best_rec_r.burst,
                  remaining: rem_dec, start: start_eff};
    if (state_r == ST_LOAD) begin
      mem_we    = !table_full;
      mem_waddr = loaded_cnt_r[IW-1:0];
      mem_wdata = '{arrival: arr_in_r, burst: burst_in_r,
                    remaining: burst_in_r, start: '0};
    end else if (state_r == ST_PICK) begin
      mem_we = found_r;
    end
  end

  srtn_slot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (scan_rd),
    .rd_addr (scan_cnt_r[IW-1:0]),
    .rd_data (mem_rdata)
  );

  // shared subtractor operand select
  always_comb begin
    unique case (state_r)
      ST_TAT: begin
        alu_req.a = ALU_W'(ct_r);
        alu_req.b = ALU_W'(best_rec_r.arrival);
      end
      ST_WT: begin
        alu_req.a = ALU_W'(tat_r);
        alu_req.b = ALU_W'(best_rec_r.burst);
      end
      ST_RT: begin
        alu_req.a = ALU_W'(best_rec_r.start);
        alu_req.b = ALU_W'(best_rec_r.arrival);
      end
      default: begin
        // key order: remaining time, then arrival
        alu_req.a = ALU_W'({mem_rdata.remaining, mem_rdata.arrival});
        alu_req.b = ALU_W'({best_rec_r.remaining, best_rec_r.arrival});
      end
    endcase
  end

  srtn_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) begin
        state_nxt = (in_chan.command == CMD_TICK) ? ST_SCAN : ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_RES;
      ST_SCAN: if (scan_end) begin
        state_nxt = ST_PICK;
      end
      ST_PICK: state_nxt = (found_r && job_fin) ? ST_TAT : ST_RES;
      ST_TAT:  state_nxt = ST_WT;
      ST_WT:   state_nxt = ST_RT;
      ST_RT:   state_nxt = ST_RES;
      ST_RES: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      loaded_cnt_r <= '0;
      fin_cnt_r    <= '0;
      cur_time_r   <= '0;
      done_r       <= '0;
      last_valid_r <= 1'b0;
      last_slot_r  <= '0;
      scan_cnt_r   <= '0;
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        scan_cnt_r <= '0;
        pend_r     <= 1'b0;
        found_r    <= 1'b0;
      end
      if (state_r == ST_LOAD && !table_full) begin
        done_r[loaded_cnt_r[IW-1:0]] <= 1'b0;
        loaded_cnt_r                 <= loaded_cnt_r + CW'(1);
      end
      if (state_r == ST_SCAN) begin
        pend_r <= scan_rd;
        if (scan_rd) begin
          scan_cnt_r <= scan_cnt_r + CW'(1);
        end
        if (cand_take) begin
          found_r <= 1'b1;
        end
      end
      if (state_r == ST_PICK) begin
        cur_time_r <= time_inc;
        if (found_r) begin
          last_valid_r <= 1'b1;
          last_slot_r  <= best_idx_r;
          if (job_fin) begin
            done_r[best_idx_r] <= 1'b1;
            fin_cnt_r          <= fin_cnt_r + CW'(1);
          end
        end
      end
      if (state_r == ST_RES && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r        <= in_chan.command;
      arr_in_r     <= in_chan.arrival_time;
      burst_in_r   <= burst_fix;
      tick_time_r  <= cur_time_r;
      res_status_r <= STATUS_OK;
      res_slot_r   <= '0;
      res_idle_r   <= 1'b0;
      res_newseg_r <= 1'b0;
      res_fin_r    <= 1'b0;
    end
    if (state_r == ST_LOAD) begin
      res_status_r <= table_full ? STATUS_FULL : STATUS_OK;
      res_slot_r   <= table_full ? '0 : loaded_cnt_r[IW-1:0];
    end
    if (state_r == ST_SCAN) begin
      pend_idx_r <= scan_cnt_r[IW-1:0];
      if (cand_take) begin
        best_idx_r <= pend_idx_r;
        best_rec_r <= mem_rdata;
      end
    end
    if (state_r == ST_PICK) begin
      res_idle_r       <= !found_r;
      ct_r             <= time_inc;
      best_rec_r.start <= start_eff;
      if (found_r) begin
        res_slot_r   <= best_idx_r;
        res_newseg_r <= !last_valid_r || (last_slot_r != best_idx_r);
        res_fin_r    <= job_fin;
      end
    end
    if (state_r == ST_TAT) begin
      tat_r <= alu_res.diff[TIME_W-1:0];
    end
    if (state_r == ST_WT) begin
      wt_r <= alu_res.borrow ? '0 : alu_res.diff[TIME_W-1:0];
    end
    if (state_r == ST_RT) begin
      rt_r <= alu_res.diff[TIME_W-1:0];
    end
    if (state_r == ST_RES && out_free) begin
      out_r <= res_nxt;
    end
  end

  // assemble the result
  always_comb begin
    res_nxt.status          = res_status_r;
    res_nxt.slot_id         = ID_W'(res_slot_r);
    res_nxt.idle            = res_idle_r;
    res_nxt.new_segment     = res_newseg_r;
    res_nxt.segment_start   = (cmd_r == CMD_TICK) ? tick_time_r : '0;
    res_nxt.finished        = res_fin_r;
    res_nxt.completion_time = res_fin_r ? ct_r : '0;
    res_nxt.turnaround_time = res_fin_r ? tat_r : '0;
    res_nxt.waiting_time    = res_fin_r ? wt_r : '0;
    res_nxt.response_time   = res_fin_r ? rt_r : '0;
    res_nxt.all_done        = (fin_cnt_r == loaded_cnt_r);
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_r.status;
  assign out_chan.slot_id         = out_r.slot_id;
  assign out_chan.idle            = out_r.idle;
  assign out_chan.new_segment     = out_r.new_segment;
  assign out_chan.segment_start   = out_r.segment_start;
  assign out_chan.finished        = out_r.finished;
  assign out_chan.completion_time = out_r.completion_time;
  assign out_chan.turnaround_time = out_r.turnaround_time;
  assign out_chan.waiting_time    = out_r.waiting_time;
  assign out_chan.response_time   = out_r.response_time;
  assign out_chan.all_done        = out_r.all_done;

  // checks
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    fin_cnt_r <= loaded_cnt_r)
    else $error("finished count exceeds loaded count");

  a_loaded_le_slots: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_cnt_r <= SLOTS_CNT)
    else $error("loaded count exceeds table size");

  a_pick_ready_job: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK) && found_r |->
      !done_r[best_idx_r] &&
      ({{(TIME_W-ARR_W){1'b0}}, best_rec_r.arrival} <= cur_time_r))
    else $error("chosen job is finished or not yet arrived");

  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_chan.command == CMD_TICK) |=> (state_r == ST_SCAN))
    else $error("tick request did not start a scan");

endmodule
